// ----- rtl/scmc_pkg.sv -----
package scmc_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int NUM_FINGERS  = 10;
   localparam int READING_BITS = 10;

   localparam int CHANNEL_BITS = 4;
   localparam int FINGER_BITS  = 4;
   localparam int SUM_BITS     = 32;
   localparam int ADDR_BITS    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SCAN_BITS    = $clog2(NUM_CHANNELS + 1);

   typedef enum logic [1:0] {
      FUNC_SAMPLE     = 2'd0,
      FUNC_WINDOW_END = 2'd1,
      FUNC_START      = 2'd2
   } func_type;

   typedef struct packed {
      func_type                  func;
      logic [CHANNEL_BITS-1:0]   channel;
      logic [READING_BITS-1:0]   reading;
   } req_type;

   typedef struct packed {
      logic [FINGER_BITS-1:0]    finger_index;
      logic [CHANNEL_BITS-1:0]   chosen_channel;
      logic [READING_BITS-1:0]   range_min;
      logic [READING_BITS-1:0]   range_max;
      logic                      moved_found;
      logic                      all_done;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic                      capture;
      logic                      update;
      logic                      clear;
      logic                      scan_init;
      logic                      scan_rd;
      logic [ADDR_BITS-1:0]      scan_addr;
      logic                      cmp_en;
      logic                      report;
      logic [FINGER_BITS-1:0]    finger;
      logic                      last;
   } cmd_type;

endpackage

// ----- rtl/scmc_ctrl.sv -----
module scmc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  scmc_pkg::req_type   req_item,
   output logic                busy,
   output scmc_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_UPDATE = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_REPORT = 4'b1000
   } state_type;

   state_type                            state_ff, state_in;
   logic                                 running_ff, running_in;
   logic [scmc_pkg::FINGER_BITS-1:0]     finger_ff, finger_in;
   logic [scmc_pkg::SCAN_BITS-1:0]       scan_ff, scan_in;
   logic                                 cmp_vld_ff, cmp_vld_in;
   logic                                 accept;
   logic                                 ch_ok;
   logic                                 last;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign ch_ok  = (32'(req_item.channel) < 32'(scmc_pkg::NUM_CHANNELS));
   assign last   = (finger_ff == scmc_pkg::FINGER_BITS'(scmc_pkg::NUM_FINGERS - 1));

   always_comb begin
      state_in   = state_ff;
      running_in = running_ff;
      finger_in  = finger_ff;
      scan_in    = scan_ff;
      cmp_vld_in = 1'b0;

      cmd           = '0;
      cmd.finger    = finger_ff;
      cmd.last      = last;
      cmd.capture   = accept;
      cmd.scan_addr = scan_ff[scmc_pkg::ADDR_BITS-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_item.func)
                  scmc_pkg::FUNC_START: begin
                     cmd.clear  = 1'b1;
                     running_in = 1'b1;
                     finger_in  = '0;
                  end
                  scmc_pkg::FUNC_SAMPLE: begin
                     if (running_ff && ch_ok) begin
                        state_in = ST_UPDATE;
                     end
                  end
                  scmc_pkg::FUNC_WINDOW_END: begin
                     if (running_ff) begin
                        cmd.scan_init = 1'b1;
                        scan_in       = '0;
                        state_in      = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_SCAN: begin
            // compare runs one entry behind the table read
            cmd.cmp_en = cmp_vld_ff;
            if (scan_ff < scmc_pkg::SCAN_BITS'(scmc_pkg::NUM_CHANNELS)) begin
               cmd.scan_rd = 1'b1;
               scan_in     = scan_ff + 1'b1;
               cmp_vld_in  = 1'b1;
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            cmd.report = 1'b1;
            cmd.clear  = 1'b1;
            if (last) begin
               running_in = 1'b0;
            end else begin
               finger_in = finger_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         running_ff <= 1'b0;
         finger_ff  <= '0;
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         running_ff <= running_in;
         finger_ff  <= finger_in;
         scan_ff    <= scan_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

endmodule

// ----- rtl/scmc_datapath.sv -----
module scmc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  scmc_pkg::req_type   req_item,
   input  scmc_pkg::cmd_type   cmd,
   output logic                rsp_strobe,
   output scmc_pkg::rsp_type   rsp_item
);

   typedef struct packed {
      logic [scmc_pkg::SUM_BITS-1:0]     sum;
      logic [scmc_pkg::READING_BITS-1:0] prev;
      logic [scmc_pkg::READING_BITS-1:0] low;
      logic [scmc_pkg::READING_BITS-1:0] high;
   } entry_type;

   localparam entry_type EntryReset = '{
      sum:  '0,
      prev: '0,
      low:  '1,
      high: '0
   };

   entry_type                              table_mem [scmc_pkg::NUM_CHANNELS];
   logic [scmc_pkg::NUM_CHANNELS-1:0]      valid_ff;

   logic [scmc_pkg::ADDR_BITS-1:0]         rd_addr;
   entry_type                              rd_ff;
   logic                                   rd_vld_ff;
   logic [scmc_pkg::ADDR_BITS-1:0]         rd_addr_ff;
   entry_type                              cur;

   logic [scmc_pkg::ADDR_BITS-1:0]         ch_ff;
   logic [scmc_pkg::READING_BITS-1:0]      reading_ff;

   logic [scmc_pkg::READING_BITS-1:0]      diff;
   logic [scmc_pkg::SUM_BITS:0]            sum_wide;
   entry_type                              upd;

   logic [scmc_pkg::SUM_BITS-1:0]          best_sum_ff;
   logic [scmc_pkg::ADDR_BITS-1:0]         best_ch_ff;
   logic [scmc_pkg::READING_BITS-1:0]      best_low_ff;
   logic [scmc_pkg::READING_BITS-1:0]      best_high_ff;
   logic                                   found_ff;

   scmc_pkg::rsp_type                      rsp_ff;
   logic                                   strobe_ff;

   assign rd_addr = cmd.scan_rd ? cmd.scan_addr
                                : scmc_pkg::ADDR_BITS'(req_item.channel);

   // an entry not written since the last clear reads as its reset value
   assign cur = rd_vld_ff ? rd_ff : EntryReset;

   always_comb begin
      diff = (reading_ff >= cur.prev) ? (reading_ff - cur.prev) : (cur.prev - reading_ff);
      sum_wide = {1'b0, cur.sum} + (scmc_pkg::SUM_BITS + 1)'(diff);
      upd.sum  = sum_wide[scmc_pkg::SUM_BITS] ? '1 : sum_wide[scmc_pkg::SUM_BITS-1:0];
      upd.prev = reading_ff;
      upd.low  = (reading_ff < cur.low)  ? reading_ff : cur.low;
      upd.high = (reading_ff > cur.high) ? reading_ff : cur.high;
   end

   always_ff @(posedge clock) begin
      rd_ff      <= table_mem[rd_addr];
      rd_addr_ff <= rd_addr;
      if (cmd.update) begin
         table_mem[ch_ff] <= upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= valid_ff[rd_addr];
         if (cmd.clear) begin
            valid_ff <= '0;
         end else if (cmd.update) begin
            valid_ff[ch_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff      <= scmc_pkg::ADDR_BITS'(req_item.channel);
         reading_ff <= req_item.reading;
      end
   end

   // strict compare keeps the lowest channel on ties
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         best_sum_ff  <= '0;
         best_ch_ff   <= '0;
         best_low_ff  <= '0;
         best_high_ff <= '0;
         found_ff     <= 1'b0;
      end else if (cmd.cmp_en && (cur.sum > best_sum_ff)) begin
         best_sum_ff  <= cur.sum;
         best_ch_ff   <= rd_addr_ff;
         best_low_ff  <= cur.low;
         best_high_ff <= cur.high;
         found_ff     <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.report) begin
         rsp_ff.finger_index   <= cmd.finger;
         rsp_ff.chosen_channel <= scmc_pkg::CHANNEL_BITS'(best_ch_ff);
         rsp_ff.range_min      <= best_low_ff;
         rsp_ff.range_max      <= best_high_ff;
         rsp_ff.moved_found    <= found_ff;
         rsp_ff.all_done       <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.report;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ----- rtl/sensor_channel_motion_calibrator_unit.sv -----
// Finger-to-channel motion calibrator. A request is taken when start is high
// and busy is low. A start request clears the channel table and begins finger 0.
// For a sample, the table RAM is read in the accept cycle and the updated
// entry is written in the next. A window end keeps busy high from accept
// until its scan through the single read port of the channel table and the
// report state are done; its result appears on rsp_item for one cycle with
// rsp_strobe high, registered from the report state. The receiver cannot
// stall, so results must be captured on the strobe. Samples and window ends
// outside a calibration run are dropped.
module sensor_channel_motion_calibrator_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  scmc_pkg::req_type   req_item,
   output logic                busy,
   output logic                rsp_strobe,
   output scmc_pkg::rsp_type   rsp_item
);

   scmc_pkg::cmd_type cmd;

   scmc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .cmd      (cmd)
   );

   scmc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
